/* rtl/core/hcb_pkg.sv */
package hcb_pkg;

  localparam int unsigned DefMaxSymbols = 32;
  localparam int unsigned DefWeightBits = 16;
  localparam int unsigned SymBits       = 8;
  localparam int unsigned InWeightBits  = 16;
  localparam int unsigned LenBits       = 5;
  localparam int unsigned CodeBits      = 31;

  typedef enum logic [3:0] {
    StIdle,
    StRdA,
    StTakeA,
    StRdB,
    StTakeB,
    StMerge,
    StPop,
    StDecode,
    StLeaf,
    StPushR,
    StPushL
  } hcb_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_front;
    logic take_a;
    logic take_b;
    logic merge;
    logic init_walk;
    logic pop;
    logic rd_node;
    logic push_r;
    logic push_l;
    logic clear;
  } hcb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic merge_done;
    logic is_leaf;
    logic stack_empty;
  } hcb_status_t;

endpackage

/* rtl/core/huffman_code_builder_sorted.sv */
// Huffman code builder for symbol sets given in ascending weight order.
// Input channel: a transaction is accepted on a rising edge where start_i is
// high and busy_o is low. Each transaction carries one symbol and its weight;
// loading accepts one symbol per cycle and the block stays ready. The
// transaction with final_item_i set closes the set and starts the build.
// Build: for each merged node the two-queue merge reads the queue fronts,
// takes one, reads again, takes the second and writes the node; reads of the
// node weight memory are registered, one pair of queue fronts per pick. The
// tree walk pops and decodes a node, then emits a leaf or pushes both children.
// busy_o is high for the whole build and walk.
// Output channel: one transaction per leaf, in left-first depth-first order,
// shown for one cycle with out_valid_o high; end_of_codes_o marks the last.
// The receiver cannot stall, so results are never held. After the last code
// busy_o falls and the next set may load.
// Reset clears the controller and all counters; the stored set is dropped.
module huffman_code_builder_sorted import hcb_pkg::*; #(
  parameter int unsigned MaxSymbols = DefMaxSymbols,
  parameter int unsigned WeightBits = DefWeightBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [SymBits-1:0]      symbol_i,
  input  logic [InWeightBits-1:0] weight_i,
  input  logic                    final_item_i,
  output logic                    out_valid_o,
  output logic [SymBits-1:0]      out_symbol_o,
  output logic [LenBits-1:0]      code_length_o,
  output logic [CodeBits-1:0]     code_bits_o,
  output logic                    end_of_codes_o
);

  hcb_cmd_t    cmd;
  hcb_status_t status;

  hcb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .final_item_i (final_item_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy_o),
    .strobe_o     (out_valid_o)
  );

  hcb_datapath #(
    .MaxSymbols (MaxSymbols),
    .WeightBits (WeightBits)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_i      (symbol_i),
    .weight_i      (weight_i),
    .status_o      (status),
    .out_symbol_o  (out_symbol_o),
    .code_length_o (code_length_o),
    .code_bits_o   (code_bits_o)
  );

  // The last code is the one emitted when the walk stack has run empty.
  assign end_of_codes_o = out_valid_o && status.stack_empty;

  // A result is only produced inside a build.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy_o)
    else $error("result strobe while idle");

  // A non-final symbol never starts a build.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !final_item_i |=> !busy_o)
    else $error("busy after a non-final load");

  // The last code returns the block to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_codes_o |=> !busy_o)
    else $error("still busy after the last code");

  // Results are never on consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |=> !out_valid_o)
    else $error("back-to-back result strobes");

endmodule

/* rtl/core/hcb_ctrl.sv */
module hcb_ctrl import hcb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        final_item_i,
  input  hcb_status_t status_i,
  output hcb_cmd_t    cmd_o,
  output logic        busy_o,
  output logic        strobe_o
);

  hcb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    busy_o   = 1'b1;
    strobe_o = 1'b0;
    case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (final_item_i) state_d = StRdA;
        end
      end
      StRdA: begin
        if (status_i.merge_done) begin
          cmd_o.init_walk = 1'b1;
          state_d = StPop;
        end else begin
          cmd_o.rd_front = 1'b1;
          state_d = StTakeA;
        end
      end
      StTakeA: begin
        cmd_o.take_a = 1'b1;
        state_d = StRdB;
      end
      StRdB: begin
        cmd_o.rd_front = 1'b1;
        state_d = StTakeB;
      end
      StTakeB: begin
        cmd_o.take_b = 1'b1;
        state_d = StMerge;
      end
      StMerge: begin
        cmd_o.merge = 1'b1;
        state_d = StRdA;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StDecode;
      end
      StDecode: begin
        cmd_o.rd_node = 1'b1;
        state_d = status_i.is_leaf ? StLeaf : StPushR;
      end
      StLeaf: begin
        strobe_o = 1'b1;
        if (status_i.stack_empty) begin
          cmd_o.clear = 1'b1;
          state_d = StIdle;
        end else begin
          state_d = StPop;
        end
      end
      StPushR: begin
        cmd_o.push_r = 1'b1;
        state_d = StPushL;
      end
      StPushL: begin
        cmd_o.push_l = 1'b1;
        state_d = StPop;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/core/hcb_datapath.sv */
module hcb_datapath import hcb_pkg::*; #(
  parameter int unsigned MaxSymbols = DefMaxSymbols,
  parameter int unsigned WeightBits = DefWeightBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hcb_cmd_t                cmd_i,
  input  logic [SymBits-1:0]      symbol_i,
  input  logic [InWeightBits-1:0] weight_i,
  output hcb_status_t             status_o,
  output logic [SymBits-1:0]      out_symbol_o,
  output logic [LenBits-1:0]      code_length_o,
  output logic [CodeBits-1:0]     code_bits_o
);

  localparam int unsigned NodeCap = 2 * MaxSymbols;
  localparam int unsigned NW      = $clog2(NodeCap);
  localparam int unsigned LW      = $clog2(MaxSymbols);
  localparam int unsigned SW      = WeightBits + NW;
  localparam logic [InWeightBits-1:0] WMask = (WeightBits >= InWeightBits) ?
      {InWeightBits{1'b1}} : InWeightBits'((64'd1 << WeightBits) - 64'd1);

  logic [NW-1:0] cnt_q, cnt_d, n_q, lh_q, mh_q, t_q, sp_q;
  logic [NW-1:0] a_idx_q, b_idx_q;
  logic [SW-1:0] a_w_q, b_w_q;

  logic [SW-1:0] wmem [NodeCap];
  logic [NW-1:0] lmem [NodeCap];
  logic [NW-1:0] rmem [NodeCap];
  logic [SymBits-1:0] smem [MaxSymbols];
  logic [NW-1:0]      stk_node [NodeCap];
  logic [LenBits-1:0] stk_len  [NodeCap];
  logic [CodeBits-1:0] stk_code [NodeCap];

  logic [SW-1:0]       wl_rd_q, wm_rd_q;
  logic [NW-1:0]       l_rd_q, r_rd_q;
  logic [SymBits-1:0]  s_rd_q;
  logic [NW-1:0]       e_node_q;
  logic [LenBits-1:0]  e_len_q;
  logic [CodeBits-1:0] e_code_q;

  logic          room;
  logic [SW-1:0] leaf_w;
  logic          pick_leaf;
  logic [NW-1:0] pick_idx;
  logic [SW-1:0] pick_w;
  logic [NW-1:0] root;

  assign room  = cnt_q < NW'(MaxSymbols);
  assign cnt_d = room ? cnt_q + NW'(1) : cnt_q;
  assign root  = (n_q << 1) - NW'(2);

  // Only the low WeightBits bits of an incoming weight are kept.
  assign leaf_w = SW'(weight_i & WMask);

  // Ties and an empty leaf queue go to the merged queue.
  assign pick_leaf = (lh_q < n_q) && (!(mh_q < t_q) || (wl_rd_q < wm_rd_q));
  assign pick_idx  = pick_leaf ? lh_q : mh_q;
  assign pick_w    = pick_leaf ? wl_rd_q : wm_rd_q;

  assign status_o.merge_done  = t_q == ((n_q << 1) - NW'(1));
  assign status_o.is_leaf     = e_node_q < n_q;
  assign status_o.stack_empty = sp_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      n_q   <= '0;
      lh_q  <= '0;
      mh_q  <= '0;
      t_q   <= '0;
      sp_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_d;
        n_q   <= cnt_d;
        lh_q  <= '0;
        mh_q  <= cnt_d;
        t_q   <= cnt_d;
      end
      if (cmd_i.take_a || cmd_i.take_b) begin
        if (pick_leaf) lh_q <= lh_q + NW'(1);
        else           mh_q <= mh_q + NW'(1);
      end
      if (cmd_i.merge)     t_q  <= t_q + NW'(1);
      if (cmd_i.init_walk) sp_q <= NW'(1);
      if (cmd_i.pop)       sp_q <= sp_q - NW'(1);
      if (cmd_i.push_r || cmd_i.push_l) sp_q <= sp_q + NW'(1);
      if (cmd_i.clear) begin
        cnt_q <= '0;
        lh_q  <= '0;
        mh_q  <= '0;
        t_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_a) begin
      a_idx_q <= pick_idx;
      a_w_q   <= pick_w;
    end
    if (cmd_i.take_b) begin
      b_idx_q <= pick_idx;
      b_w_q   <= pick_w;
    end
  end

  // Node weight memory: one write port, two read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) wmem[cnt_q] <= leaf_w;
    else if (cmd_i.merge)   wmem[t_q]   <= a_w_q + b_w_q;
    if (cmd_i.rd_front) begin
      wl_rd_q <= wmem[lh_q];
      wm_rd_q <= wmem[mh_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.merge) begin
      lmem[t_q] <= a_idx_q;
      rmem[t_q] <= b_idx_q;
    end
    if (cmd_i.rd_node) begin
      l_rd_q <= lmem[e_node_q];
      r_rd_q <= rmem[e_node_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) smem[cnt_q[LW-1:0]] <= symbol_i;
    if (cmd_i.rd_node) s_rd_q <= smem[e_node_q[LW-1:0]];
  end

  // Walk stack of (node, depth, code).
  always_ff @(posedge clk_i) begin
    if (cmd_i.init_walk) begin
      stk_node[0] <= root;
      stk_len[0]  <= '0;
      stk_code[0] <= '0;
    end else if (cmd_i.push_r) begin
      stk_node[sp_q] <= r_rd_q;
      stk_len[sp_q]  <= e_len_q + LenBits'(1);
      stk_code[sp_q] <= {e_code_q[CodeBits-2:0], 1'b1};
    end else if (cmd_i.push_l) begin
      stk_node[sp_q] <= l_rd_q;
      stk_len[sp_q]  <= e_len_q + LenBits'(1);
      stk_code[sp_q] <= {e_code_q[CodeBits-2:0], 1'b0};
    end
    if (cmd_i.pop) begin
      e_node_q <= stk_node[sp_q - NW'(1)];
      e_len_q  <= stk_len[sp_q - NW'(1)];
      e_code_q <= stk_code[sp_q - NW'(1)];
    end
  end

  assign out_symbol_o  = s_rd_q;
  assign code_length_o = e_len_q;
  assign code_bits_o   = e_code_q;

endmodule
